/* hw/rtl/rrs_pkg.sv */
// rrs_pkg: shared types, constants and index helpers of the round-robin job scheduler
// used by rrs_seq and round_robin_job_scheduler; no dependencies
package rrs_pkg;

  // store depths
  localparam int WAIT_DEPTH = 16;
  localparam int RING_DEPTH = 16;
  localparam int DONE_DEPTH = 16;

  // address and count widths
  localparam int WAIT_AW = $clog2(WAIT_DEPTH);
  localparam int WAIT_CW = $clog2(WAIT_DEPTH + 1);
  localparam int RING_AW = $clog2(RING_DEPTH);
  localparam int RING_CW = $clog2(RING_DEPTH + 1);
  localparam int DONE_AW = $clog2(DONE_DEPTH);
  localparam int DONE_CW = $clog2(DONE_DEPTH + 1);

  localparam int ID_W   = 16;
  localparam int TIME_W = 16;
  localparam int JOB_W  = ID_W + TIME_W;

  localparam logic [WAIT_CW-1:0] WAIT_FULL = WAIT_CW'(WAIT_DEPTH);
  localparam logic [RING_CW-1:0] RING_FULL = RING_CW'(RING_DEPTH);
  localparam logic [DONE_CW-1:0] DONE_FULL = DONE_CW'(DONE_DEPTH);
  localparam logic [RING_AW-1:0] RING_LAST = RING_AW'(RING_DEPTH - 1);
  localparam logic [WAIT_AW-1:0] WAIT_LAST = WAIT_AW'(WAIT_DEPTH - 1);

  // request codes
  localparam logic [1:0] REQ_LOAD    = 2'd0;
  localparam logic [1:0] REQ_PROCESS = 2'd1;
  localparam logic [1:0] REQ_UNLOAD  = 2'd2;

  // result kinds
  localparam logic KIND_PROCESS = 1'b0;
  localparam logic KIND_UNLOAD  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   jid;
    logic [TIME_W-1:0] jtime;
  } job_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ID_W-1:0]   job_id;
    logic [TIME_W-1:0] job_time;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ID_W-1:0]   out_job_id;
    logic [TIME_W-1:0] time_left;
    logic              no_job;
    logic              error;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIX
  } seq_state_t;

  // memory port bundles
  typedef struct packed {
    logic               we;
    logic [WAIT_AW-1:0] waddr;
    job_t               wdata;
    logic               re;
    logic [WAIT_AW-1:0] raddr;
  } wait_ram_t;

  typedef struct packed {
    logic               we;
    logic [RING_AW-1:0] waddr;
    job_t               wdata;
    logic               re;
    logic [RING_AW-1:0] raddr;
  } ring_ram_t;

  typedef struct packed {
    logic               we;
    logic [DONE_AW-1:0] waddr;
    logic [ID_W-1:0]    wdata;
    logic               re;
    logic [DONE_AW-1:0] raddr;
  } done_ram_t;

  // circular index helpers
  function automatic logic [RING_AW-1:0] ring_inc(input logic [RING_AW-1:0] x);
    ring_inc = (x == RING_LAST) ? '0 : RING_AW'(x + 1'b1);
  endfunction

  function automatic logic [RING_AW-1:0] ring_dec(input logic [RING_AW-1:0] x);
    ring_dec = (x == '0) ? RING_LAST : RING_AW'(x - 1'b1);
  endfunction

  function automatic logic [WAIT_AW-1:0] wait_inc(input logic [WAIT_AW-1:0] x);
    wait_inc = (x == WAIT_LAST) ? '0 : WAIT_AW'(x + 1'b1);
  endfunction

  // slot of element cnt-1 counted from start, cnt at least one
  function automatic logic [RING_AW-1:0] ring_last_slot(input logic [RING_AW-1:0] start,
                                                        input logic [RING_CW-1:0] cnt);
    logic [RING_CW:0] sum;
    sum = (RING_CW+1)'(start) + (RING_CW+1)'(cnt) - (RING_CW+1)'(1);
    if (sum >= (RING_CW+1)'(RING_DEPTH)) begin
      sum = sum - (RING_CW+1)'(RING_DEPTH);
    end
    ring_last_slot = sum[RING_AW-1:0];
  endfunction

  // slot just past the newest waiting job
  function automatic logic [WAIT_AW-1:0] wait_tail_slot(input logic [WAIT_AW-1:0] head,
                                                        input logic [WAIT_CW-1:0] cnt);
    logic [WAIT_CW:0] sum;
    sum = (WAIT_CW+1)'(head) + (WAIT_CW+1)'(cnt);
    if (sum >= (WAIT_CW+1)'(WAIT_DEPTH)) begin
      sum = sum - (WAIT_CW+1)'(WAIT_DEPTH);
    end
    wait_tail_slot = sum[WAIT_AW-1:0];
  endfunction

endpackage

/* hw/rtl/rrs_ram.sv */
// rrs_ram: generic single-write, single-read memory with registered read data
// no dependencies
module rrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, data holds between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/rrs_seq.sv */
// rrs_seq: request sequencer of the scheduler: store pointers, memory read-modify-write
// depends on rrs_pkg; drives the three store memories held in the top level
module rrs_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  rrs_pkg::in_item_t  in_item,
  output logic               in_stall,
  input  logic [15:0]        quantum,
  output rrs_pkg::wait_ram_t wait_ram,
  input  rrs_pkg::job_t      wait_rdata,
  output rrs_pkg::ring_ram_t ring_ram,
  input  rrs_pkg::job_t      ring_rdata,
  output rrs_pkg::done_ram_t done_ram,
  input  logic [rrs_pkg::ID_W-1:0] done_rdata,
  output logic               res_valid,
  output rrs_pkg::out_item_t res_item,
  input  logic               res_take
);

  rrs_pkg::seq_state_t state_r, state_nxt;
  logic unload_r, unload_nxt;
  rrs_pkg::job_t front_r, front_nxt;
  rrs_pkg::job_t fix_data_r, fix_data_nxt;
  logic [rrs_pkg::RING_AW-1:0] fix_addr_r, fix_addr_nxt;

  logic [rrs_pkg::WAIT_AW-1:0] wait_head_r, wait_head_nxt;
  logic [rrs_pkg::WAIT_CW-1:0] wait_count_r, wait_count_nxt;
  logic [rrs_pkg::RING_AW-1:0] ring_start_r, ring_start_nxt;
  logic [rrs_pkg::RING_CW-1:0] ring_count_r, ring_count_nxt;
  logic [rrs_pkg::DONE_CW-1:0] done_count_r, done_count_nxt;

  logic in_acc;
  logic fin, retire, has_wait, admit, err;
  logic [rrs_pkg::RING_AW-1:0] start1, start2, start3;
  logic [rrs_pkg::RING_CW-1:0] count1, count2;
  rrs_pkg::job_t last_job, upd_job;

  assign in_stall = (state_r != rrs_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;

  // process step: retire, admit, run the last job
  always_comb begin
    fin    = (ring_count_r != '0) && (front_r.jtime == '0);
    retire = fin && (done_count_r < rrs_pkg::DONE_FULL);
    start1 = retire ? rrs_pkg::ring_inc(ring_start_r) : ring_start_r;
    count1 = retire ? rrs_pkg::RING_CW'(ring_count_r - 1'b1) : ring_count_r;

    has_wait = (wait_count_r != '0);
    admit    = has_wait && (count1 < rrs_pkg::RING_FULL);
    start2   = admit ? rrs_pkg::ring_dec(start1) : start1;
    count2   = admit ? rrs_pkg::RING_CW'(count1 + 1'b1) : count1;
    err      = (fin && !retire) || (has_wait && !admit);

    // the last job is the admitted one when the ring was otherwise empty
    last_job = (count1 == '0) ? wait_rdata : ring_rdata;
    upd_job.jid   = last_job.jid;
    upd_job.jtime = (last_job.jtime < quantum) ? '0 : (last_job.jtime - quantum);
    start3 = (count2 > rrs_pkg::RING_CW'(1)) ? rrs_pkg::ring_dec(start2) : start2;
  end

  // result of the item in flight
  always_comb begin
    res_valid = (state_r == rrs_pkg::ST_EXEC);
    res_item  = '0;
    if (unload_r) begin
      res_item.result_kind = rrs_pkg::KIND_UNLOAD;
      if (done_count_r == '0) begin
        res_item.error = 1'b1;
      end else begin
        res_item.out_job_id = done_rdata;
      end
    end else begin
      res_item.result_kind = rrs_pkg::KIND_PROCESS;
      res_item.error       = err;
      if (count2 == '0) begin
        res_item.no_job = 1'b1;
      end else begin
        res_item.out_job_id = upd_job.jid;
        res_item.time_left  = upd_job.jtime;
      end
    end
  end

  // sequencer: next state, pointers and memory accesses
  always_comb begin
    state_nxt      = state_r;
    unload_nxt     = unload_r;
    front_nxt      = front_r;
    fix_data_nxt   = fix_data_r;
    fix_addr_nxt   = fix_addr_r;
    wait_head_nxt  = wait_head_r;
    wait_count_nxt = wait_count_r;
    ring_start_nxt = ring_start_r;
    ring_count_nxt = ring_count_r;
    done_count_nxt = done_count_r;

    wait_ram       = '0;
    wait_ram.waddr = rrs_pkg::wait_tail_slot(wait_head_r, wait_count_r);
    wait_ram.raddr = wait_head_r;
    ring_ram       = '0;
    ring_ram.raddr = rrs_pkg::ring_last_slot(ring_start_r, ring_count_r);
    done_ram       = '0;
    done_ram.waddr = done_count_r[rrs_pkg::DONE_AW-1:0];
    done_ram.wdata = front_r.jid;
    done_ram.raddr = rrs_pkg::DONE_AW'(done_count_r - 1'b1);

    case (state_r)
      rrs_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_item.req_type)
            rrs_pkg::REQ_LOAD: begin
              // append to the waiting queue, drop when full
              if (wait_count_r < rrs_pkg::WAIT_FULL) begin
                wait_ram.we       = 1'b1;
                wait_ram.wdata.jid   = in_item.job_id;
                wait_ram.wdata.jtime = in_item.job_time;
                wait_count_nxt    = rrs_pkg::WAIT_CW'(wait_count_r + 1'b1);
              end
            end
            rrs_pkg::REQ_PROCESS: begin
              wait_ram.re = 1'b1;
              ring_ram.re = 1'b1;
              unload_nxt  = 1'b0;
              state_nxt   = rrs_pkg::ST_EXEC;
            end
            rrs_pkg::REQ_UNLOAD: begin
              done_ram.re = 1'b1;
              unload_nxt  = 1'b1;
              state_nxt   = rrs_pkg::ST_EXEC;
            end
            default: begin
            end
          endcase
        end
      end
      rrs_pkg::ST_EXEC: begin
        if (res_take) begin
          state_nxt = rrs_pkg::ST_IDLE;
          if (unload_r) begin
            if (done_count_r != '0) begin
              done_count_nxt = rrs_pkg::DONE_CW'(done_count_r - 1'b1);
            end
          end else begin
            // push the finished front job
            done_ram.we = retire;
            if (retire) begin
              done_count_nxt = rrs_pkg::DONE_CW'(done_count_r + 1'b1);
            end
            if (admit) begin
              wait_head_nxt  = rrs_pkg::wait_inc(wait_head_r);
              wait_count_nxt = rrs_pkg::WAIT_CW'(wait_count_r - 1'b1);
            end
            ring_count_nxt = count2;
            ring_start_nxt = (count2 == '0) ? start2 : start3;
            if (count2 != '0) begin
              front_nxt = upd_job;
            end
            // admitted job and rotated job need two ring writes
            if (admit && (count2 > rrs_pkg::RING_CW'(1))) begin
              ring_ram.we    = 1'b1;
              ring_ram.waddr = start2;
              ring_ram.wdata = wait_rdata;
              fix_data_nxt   = upd_job;
              fix_addr_nxt   = start3;
              state_nxt      = rrs_pkg::ST_FIX;
            end else if (count2 != '0) begin
              ring_ram.we    = 1'b1;
              ring_ram.waddr = start3;
              ring_ram.wdata = upd_job;
            end
          end
        end
      end
      rrs_pkg::ST_FIX: begin
        ring_ram.we    = 1'b1;
        ring_ram.waddr = fix_addr_r;
        ring_ram.wdata = fix_data_r;
        state_nxt      = rrs_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = rrs_pkg::ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= rrs_pkg::ST_IDLE;
      wait_head_r  <= '0;
      wait_count_r <= '0;
      ring_start_r <= '0;
      ring_count_r <= '0;
      done_count_r <= '0;
    end else begin
      state_r      <= state_nxt;
      wait_head_r  <= wait_head_nxt;
      wait_count_r <= wait_count_nxt;
      ring_start_r <= ring_start_nxt;
      ring_count_r <= ring_count_nxt;
      done_count_r <= done_count_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unload_r   <= unload_nxt;
    front_r    <= front_nxt;
    fix_data_r <= fix_data_nxt;
    fix_addr_r <= fix_addr_nxt;
  end

endmodule

/* hw/rtl/round_robin_job_scheduler.sv */
// round-robin job scheduler: a load gives no item
// process and unload give their item via the output register after the store read;
// the next item is taken once the result is handed over, after a further write when
// an admitted job joins a non-empty ring (two writes on the single ring write port)
// reset clears the queue, ring and stack counters and sets quantum to 1;
// memory contents are not cleared and need no clearing pass
module round_robin_job_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  rrs_pkg::in_item_t   in_item,
  output logic                in_stall,
  output logic                out_valid,
  output rrs_pkg::out_item_t  out_item,
  input  logic                out_stall,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  logic [15:0] quantum_r;
  logic out_valid_r;
  rrs_pkg::out_item_t out_item_r;

  rrs_pkg::wait_ram_t wait_ram;
  rrs_pkg::ring_ram_t ring_ram;
  rrs_pkg::done_ram_t done_ram;
  logic [rrs_pkg::JOB_W-1:0] wait_rdata, ring_rdata;
  logic [rrs_pkg::ID_W-1:0]  done_rdata;

  logic res_valid, res_take;
  rrs_pkg::out_item_t res_item;

  // quantum register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= 16'd1;
    end else if (cfg_we) begin
      quantum_r <= cfg_wdata;
    end
  end

  // sequencer
  rrs_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .in_stall   (in_stall),
    .quantum    (quantum_r),
    .wait_ram   (wait_ram),
    .wait_rdata (rrs_pkg::job_t'(wait_rdata)),
    .ring_ram   (ring_ram),
    .ring_rdata (rrs_pkg::job_t'(ring_rdata)),
    .done_ram   (done_ram),
    .done_rdata (done_rdata),
    .res_valid  (res_valid),
    .res_item   (res_item),
    .res_take   (res_take)
  );

  // waiting queue store
  rrs_ram #(.WIDTH(rrs_pkg::JOB_W), .DEPTH(rrs_pkg::WAIT_DEPTH)) u_wait_ram (
    .clk   (clk),
    .we    (wait_ram.we),
    .waddr (wait_ram.waddr),
    .wdata (wait_ram.wdata),
    .re    (wait_ram.re),
    .raddr (wait_ram.raddr),
    .rdata (wait_rdata)
  );

  // active ring store
  rrs_ram #(.WIDTH(rrs_pkg::JOB_W), .DEPTH(rrs_pkg::RING_DEPTH)) u_ring_ram (
    .clk   (clk),
    .we    (ring_ram.we),
    .waddr (ring_ram.waddr),
    .wdata (ring_ram.wdata),
    .re    (ring_ram.re),
    .raddr (ring_ram.raddr),
    .rdata (ring_rdata)
  );

  // finished job stack
  rrs_ram #(.WIDTH(rrs_pkg::ID_W), .DEPTH(rrs_pkg::DONE_DEPTH)) u_done_ram (
    .clk   (clk),
    .we    (done_ram.we),
    .waddr (done_ram.waddr),
    .wdata (done_ram.wdata),
    .re    (done_ram.re),
    .raddr (done_ram.raddr),
    .rdata (done_rdata)
  );

  // output register
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_item_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* dv/sched_checker.sv */
// sched_checker: watches the item, report and quantum ports of the round-robin job scheduler,
// predicts every report from its own copy of the queue, ring and finished stack, and compares
// depends on rrs_pkg for the item types, store depths and request codes
module sched_checker
  import rrs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  in_item_t    in_item,
  input  logic        out_valid,
  input  logic        out_stall,
  input  out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          checked,
  output int          err_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  // mismatch lines beyond this are counted but not printed
  localparam int PRINT_CAP = 100;

  // predicted scheduler state: ring element 0 is the front
  job_t              waiting_jobs[$];
  job_t              active_ring[$];
  logic [ID_W-1:0]   finished_ids[$];
  logic [TIME_W-1:0] quantum;
  out_item_t         expected_reports[$];
  int                n_fail;
  int                n_checked;
  int                n_err;

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    if (n_fail < PRINT_CAP) begin
      $display("[%0t] report %0d: %s got %h want %h", $realtime, n_checked, what, got, want);
    end
    n_fail++;
  endtask

  // apply one accepted request to the predicted state, queue the report it causes
  task automatic apply_request(input in_item_t req);
    out_item_t rep;
    job_t      job;
    logic      err;
    rep = '0;
    err = 1'b0;
    case (req.req_type)
      REQ_LOAD: begin
        // a full queue drops the job silently
        if (waiting_jobs.size() < WAIT_DEPTH) begin
          job.jid   = req.job_id;
          job.jtime = req.job_time;
          waiting_jobs.push_back(job);
        end
      end
      REQ_PROCESS: begin
        // retire a front job with no time left, unless the stack is full
        if (active_ring.size() > 0 && active_ring[0].jtime == '0) begin
          if (finished_ids.size() < DONE_DEPTH) begin
            finished_ids.push_back(active_ring[0].jid);
            void'(active_ring.pop_front());
          end else begin
            err = 1'b1;
          end
        end
        // admit the oldest waiting job at the front, unless the ring is full
        if (waiting_jobs.size() > 0) begin
          if (active_ring.size() < RING_DEPTH) begin
            active_ring.push_front(waiting_jobs.pop_front());
          end else begin
            err = 1'b1;
          end
        end
        // run the last job one quantum and rotate it to the front
        rep.result_kind = KIND_PROCESS;
        rep.error       = err;
        if (active_ring.size() == 0) begin
          rep.no_job = 1'b1;
        end else begin
          job           = active_ring.pop_back();
          job.jtime     = (job.jtime < quantum) ? '0 : TIME_W'(job.jtime - quantum);
          rep.out_job_id = job.jid;
          rep.time_left  = job.jtime;
          active_ring.push_front(job);
        end
        expected_reports.push_back(rep);
      end
      REQ_UNLOAD: begin
        rep.result_kind = KIND_UNLOAD;
        if (finished_ids.size() == 0) begin
          rep.error = 1'b1;
        end else begin
          rep.out_job_id = finished_ids.pop_back();
        end
        expected_reports.push_back(rep);
      end
      default: begin
        // unused request code: no report, no state change
      end
    endcase
  endtask

  initial begin
    n_fail      = 0;
    n_checked   = 0;
    n_err       = 0;
    quantum     = 16'd1;
    fail_count  = 0;
    pending     = 0;
    checked     = 0;
    err_reports = 0;
  end

  // sample the ports on the rising edge, reports before new requests
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      waiting_jobs.delete();
      active_ring.delete();
      finished_ids.delete();
      expected_reports.delete();
      quantum = 16'd1;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          report("report with nothing outstanding, job id", out_item.out_job_id, 16'h0);
        end else begin
          want = expected_reports.pop_front();
          n_checked++;
          if (want.error) n_err++;
          if (out_item.result_kind !== want.result_kind)
            report("result_kind", 16'(out_item.result_kind), 16'(want.result_kind));
          if (out_item.out_job_id !== want.out_job_id)
            report("out_job_id", out_item.out_job_id, want.out_job_id);
          if (out_item.time_left !== want.time_left)
            report("time_left", out_item.time_left, want.time_left);
          if (out_item.no_job !== want.no_job)
            report("no_job", 16'(out_item.no_job), 16'(want.no_job));
          if (out_item.error !== want.error)
            report("error", 16'(out_item.error), 16'(want.error));
        end
      end
      if (in_valid && !in_stall) begin
        apply_request(in_item);
      end
      if (cfg_we) begin
        quantum = cfg_wdata;
      end
    end
    fail_count  <= n_fail;
    pending     <= expected_reports.size();
    checked     <= n_checked;
    err_reports <= n_err;
  end

endmodule

/* dv/tb.sv */
// tb: stimulus and verdict for the round-robin job scheduler under random gaps and stalls
// depends on rrs_pkg, round_robin_job_scheduler and sched_checker
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rrs_pkg::*;

  // request code the block ignores
  localparam logic [1:0] REQ_NONE = 2'd3;
  // job time profiles for loads
  localparam int TIMES_MIXED = 0;
  localparam int TIMES_SHORT = 1;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int PHASE_ITEMS  = 310;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  in_item_t    in_item;
  logic        in_stall;
  logic        out_valid;
  out_item_t   out_item;
  logic        out_stall;
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  int fail_count;
  int pending;
  int checked;
  int err_reports;
  int items_sent;
  int settings_used;
  int idle_cycles;
  bit quiet;

  round_robin_job_scheduler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_item   (in_item),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .out_stall (out_stall),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  sched_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .checked     (checked),
    .err_reports (err_reports)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // gap length: mostly none or short, a few long, none in quiet stretches
  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [15:0] rand_time(input int profile);
    int r;
    r = $urandom_range(0, 99);
    if (profile == TIMES_SHORT) return 16'($urandom_range(0, 4));
    if (r < 15) return 16'h0000;
    if (r < 25) return 16'hffff;
    if (r < 60) return 16'($urandom_range(1, 8));
    return 16'($urandom_range(0, 65535));
  endfunction

  // present one item after a random gap and hold it until taken
  task automatic send_item(input logic [1:0] req, input logic [15:0] id, input logic [15:0] t);
    int gap;
    in_item_t item;
    gap = pause_len();
    item.req_type = req;
    item.job_id   = id;
    item.job_time = t;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (in_stall);
    if (req != REQ_NONE) items_sent++;
  endtask

  // quantum changes only once every report is in and a load has settled
  task automatic write_quantum(input logic [15:0] q);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= q;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // random bursts of one request kind, weighted per phase
  task automatic run_phase(input int w_load, input int w_proc, input int profile);
    int count;
    int r;
    int burst;
    logic [1:0] req;
    count = 0;
    while (count < PHASE_ITEMS) begin
      quiet = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 3) req = REQ_NONE;
      else if (r < 3 + w_load) req = REQ_LOAD;
      else if (r < 3 + w_load + w_proc) req = REQ_PROCESS;
      else req = REQ_UNLOAD;
      burst = ($urandom_range(0, 9) < 4 && req != REQ_NONE) ? $urandom_range(2, 20) : 1;
      repeat (burst) begin
        send_item(req, 16'($urandom_range(0, 65535)), rand_time(profile));
        if (req != REQ_NONE) count++;
      end
    end
    quiet = 1'b0;
  endtask

  // result side stalls independently of the sender
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = pause_len();
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  // watchdog on cycles where no item moves on either channel
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    items_sent    = 0;
    settings_used = 1;
    quiet         = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty stores, ignored code, field extremes, retire and unload order
    send_item(REQ_UNLOAD, 16'h0000, 16'h0000);
    send_item(REQ_PROCESS, 16'h0000, 16'h0000);
    send_item(REQ_NONE, 16'hffff, 16'hffff);
    send_item(REQ_LOAD, 16'h0000, 16'h0000);
    send_item(REQ_LOAD, 16'hffff, 16'hffff);
    send_item(REQ_LOAD, 16'h1234, 16'h0001);
    repeat (5) send_item(REQ_PROCESS, 16'hffff, 16'hffff);
    repeat (3) send_item(REQ_UNLOAD, 16'h0000, 16'h0000);
    send_item(REQ_NONE, 16'h0000, 16'h0000);

    // directed: largest quantum finishes a job in one step
    write_quantum(16'hffff);
    send_item(REQ_LOAD, 16'haaaa, 16'h5555);
    repeat (2) send_item(REQ_PROCESS, 16'h0000, 16'h0000);
    send_item(REQ_UNLOAD, 16'h0000, 16'h0000);

    // zero quantum: only jobs loaded with no time end, ring and queue fill up
    write_quantum(16'h0000);
    run_phase(45, 45, TIMES_MIXED);
    // largest quantum with few unloads: finished stack fills up
    write_quantum(16'hffff);
    run_phase(45, 45, TIMES_MIXED);
    write_quantum(16'h0001);
    run_phase(35, 40, TIMES_SHORT);
    write_quantum(16'($urandom_range(0, 65535)));
    run_phase(40, 40, TIMES_MIXED);
    write_quantum(16'h0002);
    run_phase(30, 40, TIMES_SHORT);
    write_quantum(16'd300);
    run_phase(35, 40, TIMES_MIXED);

    // drain and verdict
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d requests over %0d quantum settings", items_sent, settings_used);
    $display("%0d reports compared, %0d of them with the error flag", checked, err_reports);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_ram.sv
hw/rtl/rrs_seq.sv
hw/rtl/round_robin_job_scheduler.sv
dv/sched_checker.sv
dv/tb.sv
